### sv/sct_pkg.sv
// Shared types and constants for the sensorless commutation timer.
// Holds the transaction structs, codes and the constant-divide setup.
// No dependencies.
package sct_pkg;

  // Interval history: the newest count plus HIST_DEPTH-1 stored counts.
  localparam int HIST_DEPTH = 6;
  localparam int HIST_SLOTS = HIST_DEPTH - 1;

  // Schedule compare = sum / (2 * depth), i.e. half the average interval.
  localparam int DIVISOR = 2 * HIST_DEPTH;
  localparam int SUM_W   = 16 + $clog2(HIST_DEPTH);

  function automatic int trail_zeros(input int v);
    int n;
    int x;
    n = 0;
    x = v;
    while ((x > 0) && (x[0] == 1'b0)) begin
      x = x >> 1;
      n++;
    end
    return n;
  endfunction

  // Strip the power-of-two factor as a shift, then divide by the odd part
  // through a rounded-up reciprocal, which is exact for every Q_IN_W-bit value.
  localparam int    DIV_TZ   = trail_zeros(DIVISOR);
  localparam int    DIV_ODD  = DIVISOR >> DIV_TZ;
  localparam int    Q_IN_W   = SUM_W - DIV_TZ;
  localparam int    ODD_L    = $clog2(DIV_ODD);
  localparam int    RECIP_SH = Q_IN_W + ODD_L;
  localparam int    RECIP_W  = Q_IN_W + 1;
  localparam longint RECIP_L = ((64'd1 << RECIP_SH) + DIV_ODD - 1) / DIV_ODD;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam int    PROD_W   = Q_IN_W + RECIP_W;

  // Event kinds
  localparam logic KIND_ZC  = 1'b0;
  localparam logic KIND_CMP = 1'b1;

  // Comparator codes
  localparam logic [1:0] PHASE_TWO  = 2'd2;
  localparam logic [1:0] PHASE_NONE = 2'd3;

  // Register indexes
  localparam logic CFG_DELAY_OFFSET = 1'b0;
  localparam logic CFG_DAC_TRIM     = 1'b1;

  // Duty hysteresis and detection windows
  localparam logic [15:0] DUTY_HIGH   = 16'd300;
  localparam logic [15:0] DUTY_LOW    = 16'd250;
  localparam logic [15:0] WIN_HIGH    = 16'(-80);
  localparam logic [15:0] WIN_LOW     = 16'd300;
  localparam logic [12:0] DAC_BASE    = 13'd1900;
  localparam logic [11:0] DAC_MAX     = 12'd4095;

  localparam int CFG_W = 16;

  typedef struct packed {
    logic        kind;
    logic [1:0]  phase;
    logic [15:0] interval_count;
    logic [15:0] duty;
  } in_t;

  typedef struct packed {
    logic        commutate;
    logic        schedule_valid;
    logic [15:0] compare_value;
    logic [1:0]  stop_phase;
    logic [15:0] sample_point;
    logic        high_side_mode;
    logic        dac_write;
    logic [11:0] dac_value;
  } out_t;

endpackage

### sv/sensorless_commutation_timing.sv
// Sensorless commutation timer top level: event register, one-pass update
// of history, wait flag and detection mode, and a result register.
// Depends on sct_pkg.
//
//  channel | ports                           | transaction
//  --------+---------------------------------+-------------------------------------
//  in      | in_valid / in_ready / in_data   | one zero-crossing or compare event
//  out     | out_valid / out_ready / out_data| one result per event
//  cfg     | cfg_we / cfg_index / cfg_wdata  | register write, no wait, no read-back
//
// One transaction per cycle sustained while out_ready holds high; a taken event loads
// the event register, and its result loads the result register once that is free or taken.
// The schedule divide is a shift plus one reciprocal multiply in that single pass.
// Reset is synchronous, active low, and clears history, wait flag, mode, configuration and valid flags.
// A stalled result holds everything; an event may still be taken into the empty
// event register, and in_ready drops only when both registers are full and out stalls.
module sensorless_commutation_timing (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sct_pkg::in_t           in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sct_pkg::out_t          out_data,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [sct_pkg::CFG_W-1:0] cfg_wdata
);

  // Configuration
  logic [15:0] delay_offset_r;
  logic [11:0] dac_trim_r;

  // Event register
  logic          ev_valid_r;
  sct_pkg::in_t  ev_r;

  // Result register
  logic          out_valid_r;
  sct_pkg::out_t out_r;

  // Block state
  logic [15:0]                hist_r   [sct_pkg::HIST_SLOTS];
  logic [15:0]                hist_nxt [sct_pkg::HIST_SLOTS];
  logic [sct_pkg::SUM_W-1:0]  hist_sum_r, hist_sum_nxt;
  logic                       waiting_r, waiting_nxt;
  logic                       mode_r, mode_nxt;
  logic [11:0]                last_trim_r, last_trim_nxt;

  // Advance the pipe whenever the result register is free or being taken.
  logic advance;
  logic fire;
  sct_pkg::out_t res;

  // Schedule arithmetic
  logic [sct_pkg::SUM_W-1:0]  sum_all;
  logic [sct_pkg::Q_IN_W-1:0] q_in;
  logic [sct_pkg::PROD_W-1:0] prod;
  logic [sct_pkg::PROD_W-1:0] quot;
  logic [12:0]                dac_raw;
  logic [11:0]                dac_high;
  logic                       take_zc;
  logic                       duty_hi;
  logic                       duty_lo;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !ev_valid_r || advance;
  assign fire     = ev_valid_r && advance;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Half-average interval: sum of newest count and stored history, divided down.
  assign sum_all = sct_pkg::SUM_W'(ev_r.interval_count) + hist_sum_r;
  assign q_in    = sum_all[sct_pkg::SUM_W-1:sct_pkg::DIV_TZ];
  assign prod    = sct_pkg::PROD_W'(q_in) * sct_pkg::PROD_W'(sct_pkg::RECIP);
  assign quot    = prod >> sct_pkg::RECIP_SH;

  // High-side DAC reference, saturated.
  assign dac_raw  = sct_pkg::DAC_BASE + 13'(dac_trim_r);
  assign dac_high = dac_raw[12] ? sct_pkg::DAC_MAX : dac_raw[11:0];

  assign take_zc = (ev_r.kind == sct_pkg::KIND_ZC) && !waiting_r
                   && (ev_r.phase != sct_pkg::PHASE_NONE);
  assign duty_hi = ev_r.duty > sct_pkg::DUTY_HIGH;
  assign duty_lo = ev_r.duty <= sct_pkg::DUTY_LOW;

  always_comb begin
    res           = '0;
    res.stop_phase = sct_pkg::PHASE_NONE;
    hist_nxt      = hist_r;
    hist_sum_nxt  = hist_sum_r;
    waiting_nxt   = waiting_r;
    mode_nxt      = mode_r;
    last_trim_nxt = last_trim_r;

    if (ev_r.kind == sct_pkg::KIND_CMP) begin
      // Compare match ends the wait with a commutate strobe.
      if (waiting_r) begin
        res.commutate = 1'b1;
        waiting_nxt   = 1'b0;
      end
    end else begin
      if (take_zc) begin
        res.schedule_valid = 1'b1;
        res.compare_value  = quot[15:0] + delay_offset_r;
        res.stop_phase     = ev_r.phase;
        // Drop the oldest count, append the newest.
        for (int i = 0; i < sct_pkg::HIST_SLOTS - 1; i++) begin
          hist_nxt[i] = hist_r[i+1];
        end
        hist_nxt[sct_pkg::HIST_SLOTS-1] = ev_r.interval_count;
        hist_sum_nxt = hist_sum_r - sct_pkg::SUM_W'(hist_r[0])
                       + sct_pkg::SUM_W'(ev_r.interval_count);
        waiting_nxt = 1'b1;

        // Duty hysteresis, evaluated on phase 2 only.
        if (ev_r.phase == sct_pkg::PHASE_TWO) begin
          if (duty_hi) begin
            mode_nxt = 1'b1;
            if (!mode_r || (dac_trim_r != last_trim_r)) begin
              res.dac_write = 1'b1;
              res.dac_value = dac_high;
            end
            if (dac_trim_r != last_trim_r) begin
              last_trim_nxt = dac_trim_r;
            end
          end else if (duty_lo && mode_r) begin
            res.dac_write = 1'b1;
            res.dac_value = '0;
            mode_nxt      = 1'b0;
          end
        end
      end
      // Sample point follows the mode after any change.
      res.sample_point = ev_r.duty + (mode_nxt ? sct_pkg::WIN_HIGH : sct_pkg::WIN_LOW);
    end
    res.high_side_mode = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_offset_r <= '0;
      dac_trim_r     <= '0;
      ev_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      hist_sum_r     <= '0;
      waiting_r      <= 1'b0;
      mode_r         <= 1'b0;
      last_trim_r    <= '0;
      for (int i = 0; i < sct_pkg::HIST_SLOTS; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sct_pkg::CFG_DELAY_OFFSET: delay_offset_r <= cfg_wdata[15:0];
          sct_pkg::CFG_DAC_TRIM:     dac_trim_r     <= cfg_wdata[11:0];
          default: ;
        endcase
      end
      if (in_ready) begin
        ev_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= ev_valid_r;
      end
      if (fire) begin
        hist_r      <= hist_nxt;
        hist_sum_r  <= hist_sum_nxt;
        waiting_r   <= waiting_nxt;
        mode_r      <= mode_nxt;
        last_trim_r <= last_trim_nxt;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ev_r <= in_data;
    end
    if (fire) begin
      out_r <= res;
    end
  end

`ifndef SYNTHESIS
  // A scheduled event leaves the block waiting and shows the schedule next cycle.
  a_sched_sets_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.schedule_valid) |=> (waiting_r && out_valid_r && out_r.schedule_valid))
    else $error("schedule did not set the wait flag");

  // Clearing the DAC only happens when dropping to low-side detection.
  a_dac_zero_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.dac_write && (out_r.dac_value == '0)) |-> !out_r.high_side_mode)
    else $error("zero DAC written while in high-side mode");

  // Input back-pressure only when both registers are full.
  a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (ev_valid_r && out_valid_r && !out_ready))
    else $error("in_ready low with room in the pipe");

  // A commutate strobe must clear the wait flag.
  a_commutate_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.commutate) |=> !waiting_r)
    else $error("commutate did not clear the wait flag");
`endif

endmodule

### tb/tb_sensorless_commutation_timing.sv
// Self-checking testbench for the sensorless commutation timer: directed and
// random event streams under handshake pressure, checked against a predictor.
// Depends on sct_pkg and sensorless_commutation_timing.
module tb_sensorless_commutation_timing;
  timeunit 1ns;
  timeprecision 1ps;

  // Comparator numbers below the package's named ones
  localparam logic [1:0] PHASE_ZERO = 2'd0;
  localparam logic [1:0] PHASE_ONE  = 2'd1;

  localparam int NUM_CHUNKS     = 8;
  localparam int CHUNK_EVENTS   = 250;
  localparam int SETTLE_CYCLES  = 8;     // two-stage pipe plus margin
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transaction

  // Scoreboard: carries its own copy of history, wait flag, detection mode
  // and registers, predicts one result per event and checks in order.
  class commutation_scoreboard;
    logic [15:0]   history [sct_pkg::HIST_DEPTH-1];
    bit            waiting;
    bit            high_side;
    logic [11:0]   last_trim;
    logic [15:0]   delay_offset;
    logic [11:0]   dac_trim;
    sct_pkg::out_t pending_results[$];
    int            mismatches;
    int            events_seen;
    int            results_seen;
    int            strobes;
    int            schedules;
    int            dac_writes;

    function new();
      foreach (history[i]) history[i] = '0;
      waiting      = 1'b0;
      high_side    = 1'b0;
      last_trim    = '0;
      delay_offset = '0;
      dac_trim     = '0;
      mismatches   = 0;
      events_seen  = 0;
      results_seen = 0;
      strobes      = 0;
      schedules    = 0;
      dac_writes   = 0;
    endfunction

    function void set_registers(logic [15:0] offset, logic [11:0] trim);
      delay_offset = offset;
      dac_trim     = trim;
    endfunction

    // High-side reference: base plus trim, clipped at full scale
    function logic [11:0] dac_level();
      int unsigned lvl;
      lvl = sct_pkg::DAC_BASE + dac_trim;
      return (lvl > sct_pkg::DAC_MAX) ? sct_pkg::DAC_MAX : 12'(lvl);
    endfunction

    // Work out the result of one accepted event and queue it
    function void note_event(sct_pkg::in_t ev);
      sct_pkg::out_t r;
      int unsigned   total;
      bit            was_high;
      r            = '0;
      r.stop_phase = sct_pkg::PHASE_NONE;
      events_seen++;
      if (ev.kind == sct_pkg::KIND_CMP) begin
        if (waiting) begin
          r.commutate = 1'b1;
          waiting     = 1'b0;
        end
      end else begin
        // a crossing while waiting, or with no comparator, only moves the sample point
        if (!waiting && ev.phase != sct_pkg::PHASE_NONE) begin
          total = ev.interval_count;
          foreach (history[i]) total += history[i];
          r.compare_value  = 16'(total / (2 * sct_pkg::HIST_DEPTH) + delay_offset);
          r.schedule_valid = 1'b1;
          r.stop_phase     = ev.phase;
          for (int i = 0; i < sct_pkg::HIST_DEPTH - 2; i++) history[i] = history[i+1];
          history[sct_pkg::HIST_DEPTH-2] = ev.interval_count;
          waiting = 1'b1;
          if (ev.phase == sct_pkg::PHASE_TWO) begin
            was_high = high_side;
            if (ev.duty > sct_pkg::DUTY_HIGH && !was_high) begin
              r.dac_write = 1'b1;
              r.dac_value = dac_level();
              high_side   = 1'b1;
            end
            if (ev.duty > sct_pkg::DUTY_HIGH && high_side && dac_trim != last_trim) begin
              r.dac_write = 1'b1;
              r.dac_value = dac_level();
              last_trim   = dac_trim;
            end
            if (ev.duty <= sct_pkg::DUTY_LOW && was_high) begin
              r.dac_write = 1'b1;
              r.dac_value = '0;
              high_side   = 1'b0;
            end
          end
        end
        r.sample_point = ev.duty + (high_side ? sct_pkg::WIN_HIGH : sct_pkg::WIN_LOW);
      end
      r.high_side_mode = high_side;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(sct_pkg::out_t got);
      sct_pkg::out_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: %p", got);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("commutate",      want.commutate,      got.commutate);
      compare_field("schedule_valid", want.schedule_valid, got.schedule_valid);
      compare_field("compare_value",  want.compare_value,  got.compare_value);
      compare_field("stop_phase",     want.stop_phase,     got.stop_phase);
      compare_field("sample_point",   want.sample_point,   got.sample_point);
      compare_field("high_side_mode", want.high_side_mode, got.high_side_mode);
      compare_field("dac_write",      want.dac_write,      got.dac_write);
      compare_field("dac_value",      want.dac_value,      got.dac_value);
      if (want.commutate)      strobes++;
      if (want.schedule_valid) schedules++;
      if (want.dac_write)      dac_writes++;
    endfunction
  endclass

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  sct_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  sct_pkg::out_t out_data;
  logic          cfg_we    = 1'b0;
  logic          cfg_index = sct_pkg::CFG_DELAY_OFFSET;
  logic [sct_pkg::CFG_W-1:0] cfg_wdata = '0;

  // Idle percentages, changed between phases of the run
  int tx_idle_pct = 29;
  int rx_idle_pct = 67;
  int stall_cycles = 0;

  commutation_scoreboard scoreboard = new();

  sensorless_commutation_timing dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure: drop ready at random, at the current rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Monitors: values read here are those present at the edge, so a transaction
  // is seen exactly when the block takes it.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) scoreboard.note_event(in_data);
    if (rst_n && out_valid && out_ready) scoreboard.check_result(out_data);
  end

  // Watchdog: give up once nothing has moved on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_sensorless_commutation_timing failed");
        $finish;
      end
    end
  end

  function automatic sct_pkg::in_t make_event(logic kind, logic [1:0] phase,
                                              logic [15:0] count, logic [15:0] duty);
    sct_pkg::in_t ev;
    ev.kind           = kind;
    ev.phase          = phase;
    ev.interval_count = count;
    ev.duty           = duty;
    return ev;
  endfunction

  // Bias duty towards the hysteresis thresholds, but keep full-range values too
  function automatic logic [15:0] pick_duty();
    case ($urandom_range(3))
      0: begin
        return 16'($urandom_range(310, 240));
      end
      1: begin
        return 16'($urandom_range(400));
      end
      default: begin
        return 16'($urandom);
      end
    endcase
  endfunction

  // Present one event and hold it until taken; an optional gap goes first.
  // Called at a rising edge, and returns at the edge that took the event.
  task automatic send_event(input sct_pkg::in_t ev);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and let every pending result come out, then let the pipe settle.
  // Step one edge first so the monitor has noted the last event taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (scoreboard.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers on consecutive edges; only called with the block idle
  task automatic load_settings(input logic [15:0] offset, input logic [11:0] trim);
    cfg_we    <= 1'b1;
    cfg_index <= sct_pkg::CFG_DELAY_OFFSET;
    cfg_wdata <= offset;
    @(posedge clk);
    cfg_index <= sct_pkg::CFG_DAC_TRIM;
    cfg_wdata <= sct_pkg::CFG_W'(trim);
    @(posedge clk);
    cfg_we <= 1'b0;
    scoreboard.set_registers(offset, trim);
  endtask

  task automatic set_pressure(input int chunk);
    if (chunk < 3) begin
      tx_idle_pct = 29;
      rx_idle_pct = 67;
    end else if (chunk < 6) begin
      tx_idle_pct = 67;
      rx_idle_pct = 29;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  initial begin
    int          sent;
    logic [15:0] offset;
    logic [11:0] trim;

    // Hold reset from time zero, then release it for good
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with the registers at their reset values
    set_pressure(0);
    // compare with no wait pending: no strobe
    send_event(make_event(sct_pkg::KIND_CMP, PHASE_ZERO, 16'hFFFF, 16'hFFFF));
    // first schedule with full-scale count and zero duty
    send_event(make_event(sct_pkg::KIND_ZC, PHASE_ZERO, 16'hFFFF, 16'h0000));
    // crossing while waiting; low-side window wraps past full scale
    send_event(make_event(sct_pkg::KIND_ZC, PHASE_ONE, 16'h1234, 16'hFFFF));
    send_event(make_event(sct_pkg::KIND_CMP, PHASE_ZERO, 16'h0000, 16'h0000));
    // no comparator: behaves as a crossing while waiting
    send_event(make_event(sct_pkg::KIND_ZC, sct_pkg::PHASE_NONE, 16'hFFFF, 16'd500));
    // switch to high side, writing the DAC
    send_event(make_event(sct_pkg::KIND_ZC, sct_pkg::PHASE_TWO, 16'hFFFF, 16'd301));
    send_event(make_event(sct_pkg::KIND_CMP, sct_pkg::PHASE_TWO, 16'h0000, 16'h0000));
    // high-side window below zero wraps
    send_event(make_event(sct_pkg::KIND_ZC, PHASE_ZERO, 16'hFFFF, 16'h0000));
    send_event(make_event(sct_pkg::KIND_CMP, PHASE_ZERO, 16'h0000, 16'h0000));
    // walk through the hysteresis band: mode held
    send_event(make_event(sct_pkg::KIND_ZC, sct_pkg::PHASE_TWO, 16'd1000, 16'd280));
    send_event(make_event(sct_pkg::KIND_CMP, PHASE_ZERO, 16'h0000, 16'h0000));
    send_event(make_event(sct_pkg::KIND_ZC, sct_pkg::PHASE_TWO, 16'd2000, 16'd300));
    send_event(make_event(sct_pkg::KIND_CMP, PHASE_ZERO, 16'h0000, 16'h0000));
    send_event(make_event(sct_pkg::KIND_ZC, sct_pkg::PHASE_TWO, 16'd3000, 16'd251));
    send_event(make_event(sct_pkg::KIND_CMP, PHASE_ZERO, 16'h0000, 16'h0000));
    // drop back to low side at the lower threshold
    send_event(make_event(sct_pkg::KIND_ZC, sct_pkg::PHASE_TWO, 16'd4000, 16'd250));
    send_event(make_event(sct_pkg::KIND_CMP, PHASE_ZERO, 16'h0000, 16'h0000));
    // upper threshold from the low side: mode held
    send_event(make_event(sct_pkg::KIND_ZC, sct_pkg::PHASE_TWO, 16'd5000, 16'd300));
    send_event(make_event(sct_pkg::KIND_CMP, PHASE_ZERO, 16'h0000, 16'h0000));
    send_event(make_event(sct_pkg::KIND_CMP, PHASE_ONE, 16'hFFFF, 16'hFFFF));
    send_event(make_event(sct_pkg::KIND_ZC, sct_pkg::PHASE_TWO, 16'h0000, 16'hFFFF));
    // crossing on phase two while waiting: no mode change
    send_event(make_event(sct_pkg::KIND_ZC, sct_pkg::PHASE_TWO, 16'hFFFF, 16'h0000));
    send_event(make_event(sct_pkg::KIND_CMP, PHASE_ZERO, 16'h0000, 16'h0000));
    drain();

    // Full-scale registers: offset wraps the compare, trim saturates the DAC
    // and, being new while on the high side, forces a rewrite.
    load_settings(16'hFFFF, 12'hFFF);
    send_event(make_event(sct_pkg::KIND_ZC, sct_pkg::PHASE_TWO, 16'hFFFF, 16'hFFFF));
    send_event(make_event(sct_pkg::KIND_CMP, PHASE_ZERO, 16'h0000, 16'h0000));
    drain();

    // Random part: mostly crossing/compare pairs, the rest noise
    for (int chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
      case (chunk)
        1: begin
          offset = 16'h0000;
          trim   = 12'h000;
        end
        2: begin
          offset = 16'hFFFF;
          trim   = 12'hFFF;
        end
        3: begin
          offset = 16'($urandom);
          trim   = 12'd2195;  // DAC exactly at full scale
        end
        4: begin
          offset = 16'($urandom);
          trim   = 12'd2196;  // one past full scale
        end
        5: begin
          offset = 16'h0000;
          trim   = 12'($urandom);
        end
        7: begin
          offset = 16'hFFFF;
          trim   = 12'h000;
        end
        default: begin
          offset = 16'($urandom);
          trim   = 12'($urandom);
        end
      endcase
      load_settings(offset, trim);
      set_pressure(chunk);

      sent = 0;
      while (sent < CHUNK_EVENTS) begin
        if ($urandom_range(99) < 80) begin
          send_event(make_event(sct_pkg::KIND_ZC, 2'($urandom_range(2)), 16'($urandom),
                                pick_duty()));
          send_event(make_event(sct_pkg::KIND_CMP, 2'($urandom), 16'($urandom),
                                16'($urandom)));
          sent += 2;
        end else begin
          send_event(make_event(1'($urandom), 2'($urandom), 16'($urandom), pick_duty()));
          sent++;
        end
      end
      drain();
    end

    $display("Covered %0d events and %0d results: %0d schedules, %0d commutations, %0d DAC writes",
             scoreboard.events_seen, scoreboard.results_seen, scoreboard.schedules,
             scoreboard.strobes, scoreboard.dac_writes);
    $display("across %0d register settings and three back-pressure patterns",
             NUM_CHUNKS + 2);
    if (scoreboard.mismatches == 0) begin
      $display("tb_sensorless_commutation_timing passed");
    end else begin
      $display("tb_sensorless_commutation_timing failed");
    end
    $finish;
  end

endmodule
